// ===== design/bpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Buttons scanned per tick
  localparam int unsigned NumButtons = 3;
  localparam int unsigned BtnW       = (NumButtons > 1) ? $clog2(NumButtons) : 1;

  // Field widths
  localparam int unsigned RawW     = 3;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned CodeW    = 2;
  localparam int unsigned TickW    = 10;
  localparam int unsigned DebW     = 4;
  localparam int unsigned MsW      = 20;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 20;

  // Saturation limit of the hold timer
  localparam logic [MsW-1:0] HeldMax = {MsW{1'b1}};

  // Register reset values
  localparam logic [TickW-1:0] TickPeriodRst = TickW'(10);
  localparam logic [DebW-1:0]  DebounceRst   = DebW'(2);
  localparam logic [MsW-1:0]   ShortMinRst   = MsW'(50);
  localparam logic [MsW-1:0]   LongRst       = MsW'(1000);
  localparam logic [MsW-1:0]   VeryLongRst   = MsW'(5000);

  // Depth of the request queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [CodeW-1:0] {
    EV_SHORT     = 2'd0,
    EV_LONG      = 2'd1,
    EV_VERY_LONG = 2'd2
  } ev_code_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_TICK_PERIOD = 3'd0,
    CFG_DEBOUNCE    = 3'd1,
    CFG_SHORT_MIN   = 3'd2,
    CFG_LONG        = 3'd3,
    CFG_VERY_LONG   = 3'd4,
    CFG_ACTIVE      = 3'd5
  } cfg_idx_e;

  // Events of one tick: one flag and one code per button
  typedef struct packed {
    logic [NumButtons-1:0]            mask;
    logic [NumButtons-1:0][CodeW-1:0] code;
  } ev_bundle_t;

  // Queue status seen by the top level and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== design/bpc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_front
// Holds the configuration and per-button state, debounces each tick and
// classifies the press events it causes.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bpc_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [bpc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                              accept_i,
  input  logic [bpc_pkg::RawW-1:0]          raw_levels_i,
  output logic                              q_push_o,
  output bpc_pkg::ev_bundle_t               q_data_o
);
  import bpc_pkg::*;

  // Configuration registers
  logic [TickW-1:0] tick_period_q;
  logic [DebW-1:0]  debounce_q;
  logic [MsW-1:0]   short_min_q;
  logic [MsW-1:0]   long_q;
  logic [MsW-1:0]   very_long_q;
  logic             active_q;

  // Per-button state
  logic [NumButtons-1:0]          level_q, level_d;
  logic [NumButtons-1:0][DebW-1:0] cnt_q, cnt_d;
  logic [NumButtons-1:0]          held_q, held_d;
  logic [NumButtons-1:0][MsW-1:0] ms_q, ms_d;
  logic [NumButtons-1:0]          long_done_q, long_done_d;
  logic [NumButtons-1:0]          vlong_done_q, vlong_done_d;

  logic [NumButtons-1:0] raw_ext;
  ev_bundle_t            bundle;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= TickPeriodRst;
      debounce_q    <= DebounceRst;
      short_min_q   <= ShortMinRst;
      long_q        <= LongRst;
      very_long_q   <= VeryLongRst;
      active_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_TICK_PERIOD: tick_period_q <= cfg_wdata_i[TickW-1:0];
        CFG_DEBOUNCE:    debounce_q    <= cfg_wdata_i[DebW-1:0];
        CFG_SHORT_MIN:   short_min_q   <= cfg_wdata_i[MsW-1:0];
        CFG_LONG:        long_q        <= cfg_wdata_i[MsW-1:0];
        CFG_VERY_LONG:   very_long_q   <= cfg_wdata_i[MsW-1:0];
        CFG_ACTIVE:      active_q      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Buttons above the input width sample a low level
  assign raw_ext = NumButtons'(raw_levels_i);

  // Debounce and classify every button in parallel
  always_comb begin
    logic             pressed;
    logic [DebW-1:0]  cnt_inc;
    logic [MsW:0]     sum;
    logic [MsW-1:0]   adv;
    level_d      = level_q;
    cnt_d        = cnt_q;
    held_d       = held_q;
    ms_d         = ms_q;
    long_done_d  = long_done_q;
    vlong_done_d = vlong_done_q;
    bundle       = '0;
    for (int i = 0; i < NumButtons; i++) begin
      pressed = (raw_ext[i] == active_q);
      cnt_inc = cnt_q[i] + DebW'(1);
      sum     = {1'b0, ms_q[i]} + (MsW+1)'(tick_period_q);
      adv     = (sum > {1'b0, HeldMax}) ? HeldMax : sum[MsW-1:0];

      // Flip the level after enough differing samples
      if (pressed != level_q[i]) begin
        if (cnt_inc >= debounce_q) begin
          level_d[i] = pressed;
          cnt_d[i]   = '0;
        end else begin
          cnt_d[i] = cnt_inc;
        end
      end else begin
        cnt_d[i] = '0;
      end

      // Track the hold and raise events
      if (level_d[i]) begin
        if (!held_q[i]) begin
          held_d[i]       = 1'b1;
          ms_d[i]         = '0;
          long_done_d[i]  = 1'b0;
          vlong_done_d[i] = 1'b0;
        end else begin
          ms_d[i] = adv;
          if (!vlong_done_q[i] && adv >= very_long_q) begin
            vlong_done_d[i]   = 1'b1;
            bundle.mask[i]    = 1'b1;
            bundle.code[i]    = EV_VERY_LONG;
          end else if (!long_done_q[i] && adv >= long_q) begin
            long_done_d[i]    = 1'b1;
            bundle.mask[i]    = 1'b1;
            bundle.code[i]    = EV_LONG;
          end
        end
      end else if (held_q[i]) begin
        ms_d[i]   = adv;
        held_d[i] = 1'b0;
        if (adv >= short_min_q && adv < long_q) begin
          bundle.mask[i] = 1'b1;
          bundle.code[i] = EV_SHORT;
        end
      end
    end
  end

  // Commit state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q      <= '0;
      cnt_q        <= '0;
      held_q       <= '0;
      ms_q         <= '0;
      long_done_q  <= '0;
      vlong_done_q <= '0;
    end else if (accept_i) begin
      level_q      <= level_d;
      cnt_q        <= cnt_d;
      held_q       <= held_d;
      ms_q         <= ms_d;
      long_done_q  <= long_done_d;
      vlong_done_q <= vlong_done_d;
    end
  end

  // Forward only ticks that caused events
  assign q_push_o = accept_i && (|bundle.mask);
  assign q_data_o = bundle;

endmodule

// ===== design/bpc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_queue
// Short queue of event bundles between the front and the back.
// ----------------------------------------------------------------------------
module bpc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bpc_pkg::ev_bundle_t data_i,
  input  logic                pop_i,
  output bpc_pkg::ev_bundle_t data_o,
  output bpc_pkg::q_stat_t    stat_o
);
  import bpc_pkg::*;

  ev_bundle_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the bundle
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/bpc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_back
// Takes bundles from the queue and issues their events one per cycle,
// lowest button first, into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bpc_pkg::ev_bundle_t             q_data_i,
  input  bpc_pkg::q_stat_t                q_stat_i,
  output logic                            q_pop_o,
  input  logic                            pop_i,
  output logic                            empty_o,
  output logic [bpc_pkg::IdxW-1:0]        button_index_o,
  output logic [bpc_pkg::CodeW-1:0]       event_code_o,
  output logic                            last_event_o
);
  import bpc_pkg::*;

  // Bundle being issued
  logic                  work_valid_q, work_valid_d;
  ev_bundle_t            work_q, work_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [IdxW-1:0]       out_idx_q, out_idx_d;
  logic [CodeW-1:0]      out_code_q, out_code_d;
  logic                  out_last_q, out_last_d;

  logic                  advance;
  logic [BtnW-1:0]       sel;
  logic [NumButtons-1:0] rem_mask;

  assign advance = !out_valid_q || pop_i;

  // Find the lowest pending button
  always_comb begin
    sel = '0;
    for (int i = NumButtons - 1; i >= 0; i--) begin
      if (work_q.mask[i]) begin
        sel = BtnW'(i);
      end
    end
    rem_mask      = work_q.mask;
    rem_mask[sel] = 1'b0;
  end

  // Issue one event and refill from the queue
  always_comb begin
    work_valid_d = work_valid_q;
    work_d       = work_q;
    out_valid_d  = out_valid_q;
    out_idx_d    = out_idx_q;
    out_code_d   = out_code_q;
    out_last_d   = out_last_q;
    q_pop_o      = 1'b0;
    if (advance) begin
      out_valid_d = work_valid_q;
      if (work_valid_q) begin
        out_idx_d    = IdxW'(sel);
        out_code_d   = work_q.code[sel];
        out_last_d   = (rem_mask == '0);
        work_d.mask  = rem_mask;
        work_valid_d = (rem_mask != '0);
      end
    end
    if (!work_valid_d && !q_stat_i.empty) begin
      q_pop_o      = 1'b1;
      work_d       = q_data_i;
      work_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      work_valid_q <= work_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    out_idx_q  <= out_idx_d;
    out_code_q <= out_code_d;
    out_last_q <= out_last_d;
  end

  assign empty_o        = !out_valid_q;
  assign button_index_o = out_idx_q;
  assign event_code_o   = out_code_q;
  assign last_event_o   = out_last_q;

endmodule

// ===== design/button_press_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_unit
// Debounced button scanner with short, long and very-long press events.
// ----------------------------------------------------------------------------
// The first event of a tick passes through the bundle queue, the work register
// and the output register to the result ports; further events of that tick
// follow one per cycle while they are popped. Throughput: one tick per cycle
// while the two-entry bundle queue has room; the back end issues one event per cycle.
// Reset: asynchronous, active low; all buttons released, registers at defaults.
module button_press_classifier_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bpc_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [bpc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic [bpc_pkg::RawW-1:0]        raw_levels_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [bpc_pkg::IdxW-1:0]        button_index_o,
  output logic [bpc_pkg::CodeW-1:0]       event_code_o,
  output logic                            last_event_o
);
  import bpc_pkg::*;

  logic       accept;
  logic       q_push;
  logic       q_pop;
  ev_bundle_t q_wdata;
  ev_bundle_t q_rdata;
  q_stat_t    q_stat;

  // Take a request whenever the queue has room
  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  bpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .raw_levels_i (raw_levels_i),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  bpc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  bpc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_data_i       (q_rdata),
    .q_stat_i       (q_stat),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .button_index_o (button_index_o),
    .event_code_o   (event_code_o),
    .last_event_o   (last_event_o)
  );

endmodule

// ===== verif/button_press_classifier_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_unit_tb
// Self-checking bench for the button press classifier. Scan ticks go in on
// the push side and a scoreboard predicts the short, long and very-long
// events of each accepted tick. Every popped event is checked in order. The
// run covers reset defaults, zero settings and random press sequences under
// several register settings, with random gaps and a long stall on the event
// side.
// ----------------------------------------------------------------------------
module button_press_classifier_unit_tb;
  import bpc_pkg::*;

  localparam int unsigned DrainCycles = 12;
  localparam logic [CfgAddrW-1:0] CfgSpareFirst = CfgAddrW'(CFG_ACTIVE) + CfgAddrW'(1);

  typedef struct {
    logic [IdxW-1:0] btn;
    ev_code_e        code;
    logic            last;
  } press_event_t;

  typedef struct {
    logic [TickW-1:0] tick_ms;
    logic [DebW-1:0]  deb;
    logic [MsW-1:0]   short_min;
    logic [MsW-1:0]   long_th;
    logic [MsW-1:0]   vlong_th;
    logic             active;
  } press_setup_t;

  // Predict press events per tick and hold them until they are popped
  class press_scoreboard;
    press_setup_t    cfg;
    logic            level      [NumButtons];
    logic [DebW-1:0] bounce     [NumButtons];
    logic            held       [NumButtons];
    logic [MsW-1:0]  held_ms    [NumButtons];
    logic            long_hit   [NumButtons];
    logic            vlong_hit  [NumButtons];
    press_event_t    pending[$];
    int unsigned     errors;

    function new();
      cfg.tick_ms   = TickPeriodRst;
      cfg.deb       = DebounceRst;
      cfg.short_min = ShortMinRst;
      cfg.long_th   = LongRst;
      cfg.vlong_th  = VeryLongRst;
      cfg.active    = 1'b0;
      foreach (level[i]) begin
        level[i]     = 1'b0;
        bounce[i]    = '0;
        held[i]      = 1'b0;
        held_ms[i]   = '0;
        long_hit[i]  = 1'b0;
        vlong_hit[i] = 1'b0;
      end
      errors = 0;
    endfunction

    // Apply a register write; drop writes to unused indexes
    function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_TICK_PERIOD: cfg.tick_ms   = data[TickW-1:0];
        CFG_DEBOUNCE:    cfg.deb       = data[DebW-1:0];
        CFG_SHORT_MIN:   cfg.short_min = data[MsW-1:0];
        CFG_LONG:        cfg.long_th   = data[MsW-1:0];
        CFG_VERY_LONG:   cfg.vlong_th  = data[MsW-1:0];
        CFG_ACTIVE:      cfg.active    = data[0];
        default: ;
      endcase
    endfunction

    // Advance a hold timer by one tick period, saturating
    function logic [MsW-1:0] add_tick(logic [MsW-1:0] ms);
      logic [MsW:0] sum;
      sum = {1'b0, ms} + (MsW+1)'(cfg.tick_ms);
      return sum[MsW] ? HeldMax : sum[MsW-1:0];
    endfunction

    function void note_tick(logic [RawW-1:0] raw);
      press_event_t ev;
      logic         pressed;
      logic         fire;
      int           first;
      first = pending.size();
      for (int i = 0; i < NumButtons; i++) begin
        pressed = (raw[i] == cfg.active);
        // Debounce: flip only after enough differing samples
        if (pressed != level[i]) begin
          bounce[i] = bounce[i] + 1'b1;
          if (bounce[i] >= cfg.deb) begin
            level[i]  = pressed;
            bounce[i] = '0;
          end
        end else begin
          bounce[i] = '0;
        end
        fire = 1'b0;
        if (level[i]) begin
          if (!held[i]) begin
            held[i]      = 1'b1;
            held_ms[i]   = '0;
            long_hit[i]  = 1'b0;
            vlong_hit[i] = 1'b0;
          end else begin
            held_ms[i] = add_tick(held_ms[i]);
            if (!vlong_hit[i] && held_ms[i] >= cfg.vlong_th) begin
              vlong_hit[i] = 1'b1;
              fire         = 1'b1;
              ev.code      = EV_VERY_LONG;
            end else if (!long_hit[i] && held_ms[i] >= cfg.long_th) begin
              long_hit[i] = 1'b1;
              fire        = 1'b1;
              ev.code     = EV_LONG;
            end
          end
        end else if (held[i]) begin
          held_ms[i] = add_tick(held_ms[i]);
          held[i]    = 1'b0;
          if (held_ms[i] >= cfg.short_min && held_ms[i] < cfg.long_th) begin
            fire    = 1'b1;
            ev.code = EV_SHORT;
          end
        end
        if (fire) begin
          ev.btn  = IdxW'(i);
          ev.last = 1'b0;
          pending.push_back(ev);
        end
      end
      // Mark the final event of this tick
      if (pending.size() > first) begin
        ev      = pending.pop_back();
        ev.last = 1'b1;
        pending.push_back(ev);
      end
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_event(logic [IdxW-1:0] btn, logic [CodeW-1:0] code, logic last);
      press_event_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected event: button %0d code %0d last %0b", btn, code, last));
        return;
      end
      want = pending.pop_front();
      if (btn !== want.btn)
        report($sformatf("button_index %0d, expected %0d", btn, want.btn));
      if (code !== want.code)
        report($sformatf("event_code %0d, expected %0d (button %0d)", code, want.code, want.btn));
      if (last !== want.last)
        report($sformatf("last_event %0b, expected %0b (button %0d)", last, want.last, want.btn));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                push;
  logic                full;
  logic [RawW-1:0]     raw_levels_i;
  logic                empty;
  logic                pop;
  logic [IdxW-1:0]     button_index_o;
  logic [CodeW-1:0]    event_code_o;
  logic                last_event_o;

  press_scoreboard board;
  press_setup_t    cur;
  int unsigned     tx_idle_pct    = 35;
  int unsigned     rx_idle_pct    = 48;
  int unsigned     rx_hold_cycles = 0;
  int unsigned     hold_span;
  logic            want_press[NumButtons];
  int unsigned     dwell     [NumButtons];

  button_press_classifier_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .raw_levels_i   (raw_levels_i),
    .empty          (empty),
    .pop            (pop),
    .button_index_o (button_index_o),
    .event_code_o   (event_code_o),
    .last_event_o   (last_event_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offer one tick request, with a random gap first, and hold it until taken
  task automatic send_tick(input logic [RawW-1:0] lv);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    raw_levels_i <= lv;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_tick(lv);
  endtask

  task automatic send_run(input logic [RawW-1:0] lv, input int unsigned n);
    repeat (n) send_tick(lv);
  endtask

  // Stop offering, wait for every predicted event, then let the pipe settle
  task automatic drain();
    push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    board.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Write all registers, with junk in unused upper bits, then an unused index
  task automatic apply_setup(input press_setup_t s);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    put_reg(CFG_TICK_PERIOD, {junk[CfgDataW-1:TickW], s.tick_ms});
    put_reg(CFG_DEBOUNCE, {junk[CfgDataW-1:DebW], s.deb});
    put_reg(CFG_SHORT_MIN, CfgDataW'(s.short_min));
    put_reg(CFG_LONG, CfgDataW'(s.long_th));
    put_reg(CFG_VERY_LONG, CfgDataW'(s.vlong_th));
    put_reg(CFG_ACTIVE, {junk[CfgDataW-1:1], s.active});
    put_reg(CfgSpareFirst + CfgAddrW'($urandom_range(0, 1)), CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    cur = s;
  endtask

  // Build raw levels from press and release spans, with glitches and noise
  function automatic logic [RawW-1:0] next_raw();
    logic [RawW-1:0] lv;
    for (int i = 0; i < NumButtons; i++) begin
      if (dwell[i] == 0) begin
        want_press[i] = !want_press[i];
        if ($urandom_range(0, 99) < 15)
          dwell[i] = $urandom_range(1, cur.deb + 1);
        else if (want_press[i])
          dwell[i] = cur.deb + $urandom_range(1, hold_span);
        else
          dwell[i] = cur.deb + $urandom_range(1, 6);
      end
      dwell[i]--;
      lv[i] = want_press[i] ? cur.active : !cur.active;
      if ($urandom_range(0, 99) < 4) lv[i] = !lv[i];
    end
    return lv;
  endfunction

  // One random phase: new settings, idle pattern, then random ticks
  task automatic random_phase(input int unsigned phase);
    press_setup_t s;
    int unsigned  k_long;
    int unsigned  k_vlong;
    s.tick_ms = TickW'($urandom_range(1, 1000));
    s.deb     = DebW'($urandom_range(1, 15));
    s.active  = 1'($urandom_range(0, 1));
    k_long    = $urandom_range(2, 12);
    k_vlong   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, k_long)
                                            : k_long + $urandom_range(1, 12);
    case (phase)
      0: begin
        s.tick_ms = TickW'(1);
        s.deb     = DebW'(1);
        s.active  = 1'b1;
      end
      1: begin
        s.tick_ms = {TickW{1'b1}};
        s.deb     = {DebW{1'b1}};
        s.active  = 1'b0;
      end
      5: begin
        s.deb   = DebW'(1);
        k_long  = 2;
        k_vlong = 4;
      end
      default: ;
    endcase
    s.short_min = MsW'(s.tick_ms * $urandom_range(0, k_long));
    s.long_th   = MsW'(s.tick_ms * k_long);
    s.vlong_th  = MsW'(s.tick_ms * k_vlong);
    drain();
    apply_setup(s);
    hold_span   = ((k_long > k_vlong) ? k_long : k_vlong) + 4;
    tx_idle_pct = (phase < 2) ? 35 : (phase < 4) ? 48 : 0;
    rx_idle_pct = (phase < 2) ? 48 : (phase < 4) ? 35 : 0;
    // Stall the event side for a long stretch so the block backs up
    if (phase == 5) rx_hold_cycles = 300;
    repeat (24) send_tick(next_raw());
  endtask

  // Event side: check each popped event, then decide the next pop
  initial begin : event_sink
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty)
        board.check_event(button_index_o, event_code_o, last_event_o);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    press_setup_t s;
    board = new();
    rst_ni       <= 1'b0;
    push         <= 1'b0;
    raw_levels_i <= '0;
    cfg_we_i     <= 1'b0;
    cfg_addr_i   <= '0;
    cfg_wdata_i  <= '0;
    cur          = board.cfg;
    hold_span    = 8;
    foreach (want_press[i]) begin
      want_press[i] = 1'b0;
      dwell[i]      = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults, active low: short press, too-short press, glitch,
    // and all three buttons released on the same tick
    send_run(3'b111, 2);
    send_run(3'b110, 7);
    send_run(3'b111, 3);
    send_run(3'b101, 3);
    send_run(3'b111, 2);
    send_run(3'b011, 1);
    send_run(3'b000, 8);
    send_run(3'b111, 3);

    // Zero period, debounce and thresholds: very-long then long on
    // consecutive ticks, release with no event
    drain();
    s = '{tick_ms: '0, deb: '0, short_min: '0, long_th: '0, vlong_th: '0, active: 1'b1};
    apply_setup(s);
    send_run(3'b111, 3);
    send_run(3'b000, 2);
    // Non-zero long threshold: the release now gives short events
    drain();
    s.long_th = MsW'(5);
    apply_setup(s);
    send_run(3'b111, 2);
    send_run(3'b000, 1);

    for (int unsigned p = 0; p < 6; p++) random_phase(p);

    drain();
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
